/* rtl/param_string_stack_interpreter_unit_macros.svh */
// assertion macros for the parameter string stack interpreter
`ifndef PARAM_STRING_STACK_INTERPRETER_UNIT_MACROS_SVH
`define PARAM_STRING_STACK_INTERPRETER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PSSI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pssi assertion failed");

// antecedent implies consequent in the following cycle
`define PSSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pssi assertion failed");

`endif

/* rtl/pssi_pkg.sv */
// shared types and constants for the parameter string stack interpreter
`timescale 1ns / 1ps

package pssi_pkg;

    localparam int PSSI_STACK_DEPTH = 32;
    localparam int PSSI_PARAM_COUNT = 9;
    localparam logic [7:0] PSSI_NULL_CODE = 8'h80;
    localparam logic [7:0] PSSI_ASCII_ZERO = 8'h30;
    localparam logic [7:0] PSSI_ASCII_MINUS = 8'h2d;
    localparam logic [31:0] PSSI_RECIP_TEN = 32'hcccccccd;
    localparam int PSSI_MAX_DIGITS = 10;

    typedef enum logic [3:0] {
        MODE_LOAD      = 4'd0,
        MODE_NULL      = 4'd1,
        MODE_LITERAL   = 4'd2,
        MODE_OUTCHAR   = 4'd3,
        MODE_OUTDEC    = 4'd4,
        MODE_PUSHPARAM = 4'd5,
        MODE_PUSHCONST = 4'd6,
        MODE_ADD       = 4'd7,
        MODE_SUB       = 4'd8,
        MODE_MUL       = 4'd9,
        MODE_DIV       = 4'd10,
        MODE_MOD       = 4'd11,
        MODE_INC       = 4'd12,
        MODE_END       = 4'd13
    } mode_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_LOAD_PARAM,
        DP_INC,
        DP_SET_PARAM,
        DP_SET_CONST,
        DP_POP_REQ,
        DP_POP_B,
        DP_POP_A,
        DP_ALU,
        DP_DIV_ZERO,
        DP_DIV_START,
        DP_DIV_STEP,
        DP_DIV_FIN,
        DP_PUSH,
        DP_EMIT,
        DP_DEC_START,
        DP_DEC_MUL,
        DP_DEC_SUB
    } dp_op_t;

    typedef enum logic [2:0] {
        EM_NULL,
        EM_LIT,
        EM_LOWB,
        EM_MINUS,
        EM_DIGIT,
        EM_END
    } emit_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_B_REQ,
        S_POP_B,
        S_POP_A_REQ,
        S_POP_A,
        S_ARITH,
        S_DIV,
        S_DIV_FIN,
        S_PUSH,
        S_EMIT_ONE,
        S_DEC_START,
        S_DEC_MINUS,
        S_DEC_MUL,
        S_DEC_SUB,
        S_DEC_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        emit_t      em;
        logic [3:0] mode;
    } cmd_t;

    typedef struct packed {
        logic b_zero;
        logic b_neg;
        logic div_last;
        logic dec_more;
        logic k_one;
        logic out_free;
    } status_t;

endpackage

/* rtl/pssi_ctrl.sv */
// sequencer for the parameter string stack interpreter
`timescale 1ns / 1ps

module pssi_ctrl
    import pssi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [3:0] mode,
    output logic       in_stall,
    input  status_t    status,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [3:0] mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_NULL;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd.op     = DP_NOP;
        cmd.em     = EM_NULL;
        cmd.mode   = mode_reg;
        in_stall   = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LATCH;
                    mode_next  = mode;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (mode_reg)
                    MODE_LOAD:
                    begin
                        cmd.op     = DP_LOAD_PARAM;
                        state_next = S_IDLE;
                    end
                    MODE_NULL, MODE_LITERAL, MODE_END:
                        state_next = S_EMIT_ONE;
                    MODE_OUTCHAR, MODE_OUTDEC, MODE_ADD, MODE_SUB, MODE_MUL,
                    MODE_DIV, MODE_MOD:
                        state_next = S_POP_B_REQ;
                    MODE_PUSHPARAM:
                    begin
                        cmd.op     = DP_SET_PARAM;
                        state_next = S_PUSH;
                    end
                    MODE_PUSHCONST:
                    begin
                        cmd.op     = DP_SET_CONST;
                        state_next = S_PUSH;
                    end
                    MODE_INC:
                    begin
                        cmd.op     = DP_INC;
                        state_next = S_IDLE;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_POP_B_REQ:
            begin
                cmd.op     = DP_POP_REQ;
                state_next = S_POP_B;
            end
            S_POP_B:
            begin
                cmd.op = DP_POP_B;
                if (mode_reg == MODE_OUTCHAR)
                    state_next = S_EMIT_ONE;
                else if (mode_reg == MODE_OUTDEC)
                    state_next = S_DEC_START;
                else
                    state_next = S_POP_A_REQ;
            end
            S_POP_A_REQ:
            begin
                cmd.op     = DP_POP_REQ;
                state_next = S_POP_A;
            end
            S_POP_A:
            begin
                cmd.op     = DP_POP_A;
                state_next = S_ARITH;
            end
            S_ARITH:
            begin
                if (mode_reg == MODE_DIV || mode_reg == MODE_MOD)
                begin
                    if (status.b_zero)
                    begin
                        cmd.op     = DP_DIV_ZERO;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        cmd.op     = DP_DIV_START;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    cmd.op     = DP_ALU;
                    state_next = S_PUSH;
                end
            end
            S_DIV:
            begin
                cmd.op = DP_DIV_STEP;
                if (status.div_last)
                    state_next = S_DIV_FIN;
            end
            S_DIV_FIN:
            begin
                cmd.op     = DP_DIV_FIN;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.op     = DP_PUSH;
                state_next = S_IDLE;
            end
            S_EMIT_ONE:
            begin
                if (mode_reg == MODE_NULL)
                    cmd.em = EM_NULL;
                else if (mode_reg == MODE_LITERAL)
                    cmd.em = EM_LIT;
                else if (mode_reg == MODE_OUTCHAR)
                    cmd.em = EM_LOWB;
                else
                    cmd.em = EM_END;
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_IDLE;
                end
            end
            S_DEC_START:
            begin
                cmd.op     = DP_DEC_START;
                state_next = status.b_neg ? S_DEC_MINUS : S_DEC_MUL;
            end
            S_DEC_MINUS:
            begin
                cmd.em = EM_MINUS;
                if (status.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = S_DEC_MUL;
                end
            end
            S_DEC_MUL:
            begin
                cmd.op     = DP_DEC_MUL;
                state_next = S_DEC_SUB;
            end
            S_DEC_SUB:
            begin
                cmd.op     = DP_DEC_SUB;
                state_next = status.dec_more ? S_DEC_MUL : S_DEC_EMIT;
            end
            S_DEC_EMIT:
            begin
                cmd.em = EM_DIGIT;
                if (status.out_free)
                begin
                    cmd.op = DP_EMIT;
                    if (status.k_one)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

/* rtl/pssi_dp.sv */
// datapath: operand stack, parameters, alu, divider, decimal converter, output register
`timescale 1ns / 1ps

module pssi_dp
    import pssi_pkg::*;
#(
    parameter int STACK_DEPTH = PSSI_STACK_DEPTH,
    parameter int PARAM_COUNT = PSSI_PARAM_COUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [7:0]         operand,
    input  logic signed [31:0] load_value,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;

    logic [31:0] stack_mem [STACK_DEPTH];
    logic [31:0] param_reg [PARAM_COUNT];

    logic [CW-1:0] count_reg;
    logic          fault_reg;
    logic          under_reg;
    logic [31:0]   rd_data_reg;
    logic [7:0]    opnd_reg;
    logic [31:0]   lval_reg;
    logic [31:0]   a_reg, b_reg, res_reg;

    // restoring divider on magnitudes
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [4:0]  dcnt_reg;

    // decimal conversion
    logic [31:0] m_reg;
    logic [28:0] q_reg;
    logic [3:0]  dig_reg [PSSI_MAX_DIGITS];
    logic [3:0]  k_reg;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_reg, error_reg;

    logic          idx_ok;
    logic [PW-1:0] pidx;
    logic          out_free;
    logic [31:0]   pop_val;
    logic [31:0]   mag_a, mag_b;
    logic [32:0]   trial;
    logic [31:0]   rem_shift;
    logic [63:0]   q_prod;
    logic [31:0]   q_ext;
    logic [31:0]   dig_full;
    logic [7:0]    emit_byte;
    logic [3:0]    k_dec;

    assign idx_ok    = (opnd_reg != 8'd0) && (opnd_reg <= 8'(PARAM_COUNT));
    assign pidx      = PW'(opnd_reg - 8'd1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop_val   = under_reg ? 32'd0 : rd_data_reg;
    assign mag_a     = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign mag_b     = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign rem_shift = {rem_reg[30:0], quo_reg[31]};
    assign trial     = {1'b0, rem_shift} - {1'b0, dvs_reg};
    assign q_prod    = m_reg * PSSI_RECIP_TEN;
    assign q_ext     = {3'd0, q_reg};
    assign dig_full  = m_reg - (q_ext << 3) - (q_ext << 1);
    assign k_dec     = k_reg - 4'd1;

    always_comb
    begin
        case (cmd.em)
            EM_NULL:  emit_byte = PSSI_NULL_CODE;
            EM_LIT:   emit_byte = opnd_reg;
            EM_LOWB:  emit_byte = b_reg[7:0];
            EM_MINUS: emit_byte = PSSI_ASCII_MINUS;
            EM_DIGIT: emit_byte = PSSI_ASCII_ZERO + {4'd0, dig_reg[k_dec]};
            default:  emit_byte = 8'd0;
        endcase
    end

    assign status.b_zero   = (b_reg == 32'd0);
    assign status.b_neg    = b_reg[31];
    assign status.div_last = (dcnt_reg == 5'd31);
    assign status.dec_more = (q_reg != 29'd0) && (k_reg < 4'(PSSI_MAX_DIGITS - 1));
    assign status.k_one    = (k_reg == 4'd1);
    assign status.out_free = out_free;

    // stack storage, write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_PUSH && count_reg != CW'(STACK_DEPTH))
            stack_mem[count_reg[AW-1:0]] <= res_reg;
        if (cmd.op == DP_POP_REQ && count_reg != '0)
            rd_data_reg <= stack_mem[AW'(count_reg - CW'(1))];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PARAM_COUNT; i++)
                param_reg[i] <= 32'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                DP_LOAD_PARAM:
                begin
                    if (idx_ok)
                        param_reg[pidx] <= lval_reg;
                    else
                        fault_reg <= 1'b1;
                end
                DP_INC:
                begin
                    param_reg[0] <= param_reg[0] + 32'd1;
                    param_reg[1] <= param_reg[1] + 32'd1;
                end
                DP_SET_PARAM:
                    if (!idx_ok)
                        fault_reg <= 1'b1;
                DP_POP_REQ:
                begin
                    if (count_reg == '0)
                        fault_reg <= 1'b1;
                    else
                        count_reg <= count_reg - CW'(1);
                end
                DP_DIV_ZERO:
                    fault_reg <= 1'b1;
                DP_PUSH:
                begin
                    if (count_reg == CW'(STACK_DEPTH))
                        fault_reg <= 1'b1;
                    else
                        count_reg <= count_reg + CW'(1);
                end
                DP_EMIT:
                begin
                    out_valid_reg <= 1'b1;
                    if (cmd.em == EM_END)
                        count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LATCH:
            begin
                opnd_reg <= operand;
                lval_reg <= load_value;
            end
            DP_SET_PARAM:
                res_reg <= idx_ok ? param_reg[pidx] : 32'd0;
            DP_SET_CONST:
                res_reg <= {24'd0, opnd_reg};
            DP_POP_REQ:
                under_reg <= (count_reg == '0);
            DP_POP_B:
                b_reg <= pop_val;
            DP_POP_A:
                a_reg <= pop_val;
            DP_ALU:
            begin
                if (cmd.mode == MODE_ADD)
                    res_reg <= a_reg + b_reg;
                else if (cmd.mode == MODE_SUB)
                    res_reg <= a_reg - b_reg;
                else
                    res_reg <= a_reg * b_reg;
            end
            DP_DIV_ZERO:
                res_reg <= 32'd0;
            DP_DIV_START:
            begin
                rem_reg  <= 32'd0;
                quo_reg  <= mag_a;
                dvs_reg  <= mag_b;
                dcnt_reg <= 5'd0;
            end
            DP_DIV_STEP:
            begin
                if (!trial[32])
                    rem_reg <= trial[31:0];
                else
                    rem_reg <= rem_shift;
                quo_reg  <= {quo_reg[30:0], !trial[32]};
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            DP_DIV_FIN:
            begin
                if (cmd.mode == MODE_DIV)
                    res_reg <= (a_reg[31] != b_reg[31]) ? (32'd0 - quo_reg) : quo_reg;
                else
                    res_reg <= a_reg[31] ? (32'd0 - rem_reg) : rem_reg;
            end
            DP_DEC_START:
            begin
                m_reg <= mag_b;
                k_reg <= 4'd0;
            end
            DP_DEC_MUL:
                q_reg <= q_prod[63:35];
            DP_DEC_SUB:
            begin
                dig_reg[k_reg] <= dig_full[3:0];
                k_reg          <= k_reg + 4'd1;
                m_reg          <= q_ext;
            end
            DP_EMIT:
            begin
                out_byte_reg <= emit_byte;
                last_reg     <= (cmd.em == EM_END);
                error_reg    <= (cmd.em == EM_END) && fault_reg;
                if (cmd.em == EM_DIGIT)
                    k_reg <= k_dec;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

endmodule

/* rtl/param_string_stack_interpreter_unit.sv */
// top level of the parameter string stack interpreter
`timescale 1ns / 1ps
// usage
// - input channel (in_valid / in_stall) carries one code element per request:
//   mode, operand and load_value; parameters are loaded first with the load mode
// - output channel (out_valid / out_stall) carries generated bytes with last and
//   error; error is the sticky fault flag and is meaningful only with last
// - one request is worked on at a time; in_stall stays high until it is done
// - load, inc and unused modes finish in decode; null, literal and end emit one
//   byte after any wait on the output register; pushes go to push; outchar pops
//   then emits; add, sub, mul pop two operands, compute and push; div and mod
//   with a nonzero divisor run the one-bit-per-cycle restoring divider; outdec
//   runs the multiply-by-reciprocal digit loop, then emits a byte per free cycle
// - first output byte appears in the cycle after its emit step, from a register
// - a stalled output holds its byte; the sequencer waits at the next emit step
//   while work that emits nothing continues
// - reset empties the stack, clears parameters and the fault flag; stack entries
//   are never read unless pushed, so no clearing pass is needed
module param_string_stack_interpreter_unit
    import pssi_pkg::*;
#(
    parameter int STACK_DEPTH = PSSI_STACK_DEPTH,
    parameter int PARAM_COUNT = PSSI_PARAM_COUNT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         mode,
    input  logic [7:0]         operand,
    input  logic signed [31:0] load_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         out_byte,
    output logic               last,
    output logic               error
);

`include "param_string_stack_interpreter_unit_macros.svh"

    cmd_t    cmd;
    status_t status;

    // sequencer
    pssi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // stack, arithmetic and output register
    pssi_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .PARAM_COUNT (PARAM_COUNT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .operand    (operand),
        .load_value (load_value),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_byte   (out_byte),
        .last       (last),
        .error      (error)
    );

    // an accepted request keeps the input stalled while it runs
    `PSSI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // emits are only issued when the output register can take them
    `PSSI_ASSERT_SAME(a_emit_when_free, cmd.op == DP_EMIT, status.out_free)
    // error flag only rides on the terminating byte
    `PSSI_ASSERT_SAME(a_error_with_last, out_valid && error, last)

endmodule
